// ----- rtl/lj_pkg.sv -----
// shared types, constants and helpers for the lennard-jones pair force block
package lj_pkg;

    localparam int FRAC_BITS = 16;
    localparam int SEP_W     = 24;
    localparam int ID_W      = 20;
    localparam int OUT_W     = 32;
    localparam int S6_W      = 24;
    localparam int EPS_W     = 32;
    localparam int CUT_W     = 24;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int SQ_W      = 2 * SEP_W;
    localparam int R_W       = CUT_W + FRAC_BITS;
    localparam int Q_W       = 64;
    localparam int DIV_STEPS = 33 + 2 * FRAC_BITS;
    localparam int SH_NARROW = 32;
    localparam int SH_WIDE   = 32 + FRAC_BITS;
    localparam int EN_SHIFT  = 32 - FRAC_BITS;
    localparam int EPS_SHIFT = 8;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [S6_W-1:0]  SIGMA_SIXTH_RST = 24'd840676;
    localparam logic [EPS_W-1:0] WELL_DEPTH_RST  = 32'd142606;
    localparam logic [CUT_W-1:0] CUTOFF_SQ_RST   = 24'd1380735;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIGMA_SIXTH = 2'd0,
        CFG_WELL_DEPTH  = 2'd1,
        CFG_CUTOFF_SQ   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic                  in_range;
        logic [2:0][SEP_W-1:0] mag;
        logic [2:0]            neg;
    } t_side;

    typedef struct packed {
        t_side          side;
        logic [R_W-1:0] r2;
    } t_pair;

    typedef struct packed {
        logic                  in_range;
        logic [2:0][OUT_W-1:0] frc;
        logic [OUT_W-1:0]      eng;
        logic [5:0][OUT_W-1:0] vir;
    } t_result;

    // sign and saturate a q48.16 magnitude into a signed 32-bit q16.16 word
    function automatic logic [OUT_W-1:0] pack_q(input logic [Q_W-1:0] mag, input logic neg);
        logic [OUT_W-1:0] res;
        if (neg) begin
            if (mag >= 64'h0000_0000_8000_0000) begin
                res = 32'h8000_0000;
            end else begin
                res = ~mag[OUT_W-1:0] + 32'd1;
            end
        end else begin
            if (mag > 64'h0000_0000_7FFF_FFFF) begin
                res = 32'h7FFF_FFFF;
            end else begin
                res = mag[OUT_W-1:0];
            end
        end
        return res;
    endfunction

endpackage

// ----- rtl/lj_front.sv -----
// front end: separation magnitudes, r^2 and pair classification
module lj_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_push,
    input  logic signed [lj_pkg::SEP_W-1:0] i_sep_x,
    input  logic signed [lj_pkg::SEP_W-1:0] i_sep_y,
    input  logic signed [lj_pkg::SEP_W-1:0] i_sep_z,
    input  logic [lj_pkg::ID_W-1:0]     i_id_i,
    input  logic [lj_pkg::ID_W-1:0]     i_id_j,
    input  logic [lj_pkg::CUT_W-1:0]    i_cutoff_sq,
    output logic                        o_valid,
    output lj_pkg::t_pair               o_pair
);
    import lj_pkg::*;

    logic [2:0][SEP_W-1:0] w_sep;
    logic [2:0][SEP_W-1:0] w_mag;
    logic [2:0]            w_neg;
    logic [2:0][SQ_W-1:0]  w_sq;
    logic [SQ_W+1:0]       w_r2;
    logic                  w_in_range;

    logic                  r_f1_vld;
    logic [2:0][SEP_W-1:0] r_f1_mag;
    logic [2:0]            r_f1_neg;
    logic [2:0][SQ_W-1:0]  r_f1_sq;
    logic                  r_f1_idok;
    logic                  r_f2_vld;
    t_pair                 r_f2_pair;

    always_comb begin
        w_sep[0] = i_sep_x;
        w_sep[1] = i_sep_y;
        w_sep[2] = i_sep_z;
        for (int c = 0; c < 3; c++) begin
            w_neg[c] = w_sep[c][SEP_W-1];
            w_mag[c] = w_neg[c] ? (~w_sep[c] + 24'd1) : w_sep[c];
            w_sq[c]  = SQ_W'(w_mag[c]) * SQ_W'(w_mag[c]);
        end
    end

    always_comb begin
        w_r2 = (SQ_W+2)'(r_f1_sq[0]) + (SQ_W+2)'(r_f1_sq[1]) + (SQ_W+2)'(r_f1_sq[2]);
        w_in_range = r_f1_idok &&
                     (w_r2 <= (SQ_W+2)'({i_cutoff_sq, {FRAC_BITS{1'b0}}}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
        end else if (i_en) begin
            r_f1_vld <= i_push;
            r_f2_vld <= r_f1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f1_mag  <= w_mag;
            r_f1_neg  <= w_neg;
            r_f1_sq   <= w_sq;
            r_f1_idok <= i_id_j > i_id_i;
            r_f2_pair.side.in_range <= w_in_range;
            r_f2_pair.side.mag      <= r_f1_mag;
            r_f2_pair.side.neg      <= r_f1_neg;
            r_f2_pair.r2            <= w_r2[R_W-1:0];
        end
    end

    assign o_valid = r_f2_vld;
    assign o_pair  = r_f2_pair;

endmodule

// ----- rtl/lj_fifo.sv -----
// short queue between the front end and the arithmetic back end
module lj_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lj_pkg::t_pair i_data,
    input  logic          i_pop,
    output lj_pkg::t_pair o_data,
    output logic          o_empty,
    output logic          o_full
);
    import lj_pkg::*;

    t_pair              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));

endmodule

// ----- rtl/lj_recip.sv -----
// pipelined restoring divider: u = 2^(32+2F) / r^2, one quotient bit per stage
module lj_recip (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  lj_pkg::t_pair      i_pair,
    output logic               o_valid,
    output lj_pkg::t_side      o_side,
    output logic [lj_pkg::Q_W-1:0] o_u
);
    import lj_pkg::*;

    logic           r_vld  [DIV_STEPS+1];
    t_side          r_side [DIV_STEPS+1];
    logic [R_W-1:0] r_div  [DIV_STEPS+1];
    logic [R_W-1:0] r_rem  [DIV_STEPS+1];
    logic [Q_W-1:0] r_q    [DIV_STEPS+1];
    logic           r_sat  [DIV_STEPS+1];
    logic           r_zero [DIV_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_pair.side;
            r_div[0]  <= i_pair.r2;
            r_rem[0]  <= '0;
            r_q[0]    <= '0;
            r_sat[0]  <= 1'b0;
            r_zero[0] <= (i_pair.r2 == '0);
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        // the single one bit of the dividend enters at the first step
        localparam logic INJ = (k == 0);
        logic [R_W:0]   w_rem2;
        logic           w_ge;
        logic [R_W-1:0] w_rem_n;

        always_comb begin
            w_rem2  = {r_rem[k], INJ};
            w_ge    = w_rem2 >= {1'b0, r_div[k]};
            w_rem_n = w_ge ? R_W'(w_rem2 - {1'b0, r_div[k]}) : w_rem2[R_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k+1] <= r_side[k];
                r_div[k+1]  <= r_div[k];
                r_rem[k+1]  <= w_rem_n;
                r_q[k+1]    <= {r_q[k][Q_W-2:0], w_ge};
                r_sat[k+1]  <= r_sat[k] | r_q[k][Q_W-1];
                r_zero[k+1] <= r_zero[k];
            end
        end
    end

    assign o_valid = r_vld[DIV_STEPS];
    assign o_side  = r_side[DIV_STEPS];
    assign o_u     = (r_sat[DIV_STEPS] || r_zero[DIV_STEPS]) ? '1 : r_q[DIV_STEPS];

endmodule

// ----- rtl/lj_mul64.sv -----
// 64x64 multiply in 32x32 partial products, shifted down and saturated
module lj_mul64 (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [lj_pkg::Q_W-1:0] i_a,
    input  logic [lj_pkg::Q_W-1:0] i_b,
    input  logic                   i_wide,
    output logic [lj_pkg::Q_W-1:0] o_p
);
    import lj_pkg::*;

    logic [Q_W-1:0]   r_pp [4];
    logic             r_wide1;
    logic [2*Q_W-1:0] r_prod;
    logic             r_wide2;
    logic [Q_W-1:0]   r_p;
    logic             w_sat;
    logic [Q_W-1:0]   w_val;

    always_comb begin
        if (r_wide2) begin
            w_sat = |r_prod[2*Q_W-1:Q_W+SH_WIDE];
            w_val = r_prod[SH_WIDE+Q_W-1:SH_WIDE];
        end else begin
            w_sat = |r_prod[2*Q_W-1:Q_W+SH_NARROW];
            w_val = r_prod[SH_NARROW+Q_W-1:SH_NARROW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp[0] <= Q_W'(i_a[31:0])  * Q_W'(i_b[31:0]);
            r_pp[1] <= Q_W'(i_a[31:0])  * Q_W'(i_b[63:32]);
            r_pp[2] <= Q_W'(i_a[63:32]) * Q_W'(i_b[31:0]);
            r_pp[3] <= Q_W'(i_a[63:32]) * Q_W'(i_b[63:32]);
            r_wide1 <= i_wide;
            r_prod  <= (2*Q_W)'(r_pp[0])
                     + ((2*Q_W)'(r_pp[1]) << 32)
                     + ((2*Q_W)'(r_pp[2]) << 32)
                     + {r_pp[3], {Q_W{1'b0}}};
            r_wide2 <= r_wide1;
            r_p     <= w_sat ? '1 : w_val;
        end
    end

    assign o_p = r_p;

endmodule

// ----- rtl/lj_back.sv -----
// back end: chain of multiplies from u to force, energy and virial terms
module lj_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  lj_pkg::t_side          i_side,
    input  logic [lj_pkg::Q_W-1:0] i_u,
    input  logic [lj_pkg::Q_W-1:0] i_s6q,
    input  logic [lj_pkg::Q_W-1:0] i_pe,
    output logic                   o_valid,
    output lj_pkg::t_result        o_res
);
    import lj_pkg::*;

    localparam logic [Q_W-1:0] ONE_Q = 64'h0000_0001_0000_0000;
    localparam logic [Q_W-1:0] SIX_Q = 64'h0000_0006_0000_0000;
    localparam int PA [6] = '{0, 1, 2, 0, 0, 1};
    localparam int PB [6] = '{0, 1, 2, 1, 2, 2};

    logic           r_vld_d    [1:19];
    t_side          r_side_d   [1:19];
    logic [Q_W-1:0] r_u_d      [1:9];
    logic [Q_W-1:0] r_u6_d     [7:10];
    logic           r_eneg_d   [10:13];
    logic [Q_W-1:0] r_g_d      [11:13];
    logic           r_frneg_d  [11:19];
    logic [OUT_W-1:0] r_energy_d [14:19];
    logic [Q_W-1:0] r_t;
    logic [Q_W+3:0] r_a12;
    logic [Q_W-1:0] r_p4;
    logic [SQ_W-1:0] r_mm [6];
    logic           r_out_vld;
    t_result        r_res;

    logic [Q_W-1:0] m_u2, m_u6, m_a, m_pu, m_p3, m_em, m_fr;
    logic [Q_W-1:0] m_frc [3];
    logic [Q_W-1:0] m_vir [6];
    logic [Q_W-1:0] w_a12;
    t_result        w_res;

    lj_mul64 u_mul_u2 (.i_clk, .i_en, .i_a(i_u),       .i_b(i_u),
                       .i_wide(1'b0), .o_p(m_u2));
    lj_mul64 u_mul_u6 (.i_clk, .i_en, .i_a(m_u2),      .i_b(r_u_d[3]),
                       .i_wide(1'b0), .o_p(m_u6));
    lj_mul64 u_mul_a  (.i_clk, .i_en, .i_a(i_s6q),     .i_b(m_u6),
                       .i_wide(1'b0), .o_p(m_a));
    lj_mul64 u_mul_pu (.i_clk, .i_en, .i_a(i_pe),      .i_b(m_u6),
                       .i_wide(1'b0), .o_p(m_pu));
    lj_mul64 u_mul_em (.i_clk, .i_en, .i_a(r_u6_d[10]), .i_b(r_t),
                       .i_wide(1'b0), .o_p(m_em));
    lj_mul64 u_mul_p3 (.i_clk, .i_en, .i_a(m_pu),      .i_b(r_u_d[9]),
                       .i_wide(1'b0), .o_p(m_p3));
    lj_mul64 u_mul_fr (.i_clk, .i_en, .i_a(r_p4),      .i_b(r_g_d[13]),
                       .i_wide(1'b0), .o_p(m_fr));

    for (genvar c = 0; c < 3; c++) begin : g_frc
        lj_mul64 u_mul (.i_clk, .i_en, .i_a(m_fr), .i_b(Q_W'(r_side_d[16].mag[c])),
                        .i_wide(1'b0), .o_p(m_frc[c]));
    end

    for (genvar k = 0; k < 6; k++) begin : g_vir
        lj_mul64 u_mul (.i_clk, .i_en, .i_a(m_fr), .i_b(Q_W'(r_mm[k])),
                        .i_wide(1'b1), .o_p(m_vir[k]));
    end

    assign w_a12 = (|r_a12[Q_W+3:Q_W]) ? '1 : r_a12[Q_W-1:0];

    always_comb begin
        w_res.in_range = r_side_d[19].in_range;
        w_res.eng      = r_energy_d[19];
        for (int c = 0; c < 3; c++) begin
            w_res.frc[c] = pack_q(m_frc[c], r_frneg_d[19] ^ r_side_d[19].neg[c]);
        end
        for (int k = 0; k < 6; k++) begin
            w_res.vir[k] = pack_q(m_vir[k], !r_frneg_d[19] ^ r_side_d[19].neg[PA[k]]
                                            ^ r_side_d[19].neg[PB[k]]);
        end
        // a pair that does not count gives an all-zero result
        if (!r_side_d[19].in_range) begin
            w_res = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 19; k++) begin
                r_vld_d[k] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_vld_d[1] <= i_valid;
            for (int k = 2; k <= 19; k++) begin
                r_vld_d[k] <= r_vld_d[k-1];
            end
            r_out_vld <= r_vld_d[19];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side_d[1] <= i_side;
            for (int k = 2; k <= 19; k++) begin
                r_side_d[k] <= r_side_d[k-1];
            end
            r_u_d[1] <= i_u;
            for (int k = 2; k <= 9; k++) begin
                r_u_d[k] <= r_u_d[k-1];
            end
            r_u6_d[7] <= m_u6;
            for (int k = 8; k <= 10; k++) begin
                r_u6_d[k] <= r_u6_d[k-1];
            end
            // energy factor |a - 1| and 12a
            if (m_a >= ONE_Q) begin
                r_t         <= m_a - ONE_Q;
                r_eneg_d[10] <= 1'b0;
            end else begin
                r_t         <= ONE_Q - m_a;
                r_eneg_d[10] <= 1'b1;
            end
            r_a12 <= (Q_W+4)'({m_a, 3'b000}) + (Q_W+4)'({m_a, 2'b00});
            for (int k = 11; k <= 13; k++) begin
                r_eneg_d[k] <= r_eneg_d[k-1];
            end
            if (w_a12 >= SIX_Q) begin
                r_g_d[11]     <= w_a12 - SIX_Q;
                r_frneg_d[11] <= 1'b1;
            end else begin
                r_g_d[11]     <= SIX_Q - w_a12;
                r_frneg_d[11] <= 1'b0;
            end
            for (int k = 12; k <= 13; k++) begin
                r_g_d[k] <= r_g_d[k-1];
            end
            for (int k = 12; k <= 19; k++) begin
                r_frneg_d[k] <= r_frneg_d[k-1];
            end
            r_p4 <= (|m_p3[Q_W-1:Q_W-2]) ? '1 : {m_p3[Q_W-3:0], 2'b00};
            r_energy_d[14] <= pack_q(m_em >> EN_SHIFT, r_eneg_d[13]);
            for (int k = 15; k <= 19; k++) begin
                r_energy_d[k] <= r_energy_d[k-1];
            end
            for (int k = 0; k < 6; k++) begin
                r_mm[k] <= SQ_W'(r_side_d[15].mag[PA[k]]) * SQ_W'(r_side_d[15].mag[PB[k]]);
            end
            r_res <= w_res;
        end
    end

    assign o_valid = r_out_vld;
    assign o_res   = r_res;

endmodule

// ----- rtl/lj_pair_force.sv -----
// Lennard-Jones 12-6 pair force kernel, one candidate pair per cycle
// Input side is a queue write port: present a pair with push while full is
// low and it is taken at that edge. Result side is a queue read port: the
// oldest result sits on the o_ ports while empty is low, pop takes it.
// Exactly one result per pair, in order; a pair with id_j <= id_i or r^2
// beyond the cutoff gives in_range = 0 and all other fields zero.
// Most of the path from the accepting edge to the result is the 65-stage
// reciprocal divider plus the multiply chain. A new pair can be taken
// every cycle while full is low. When pop is held low while a result
// shows, the back end freezes and the 4-entry queue behind the front end
// keeps taking pairs until it fills, then full goes high. Reset clears
// all valid bits and loads the default sigma^6, epsilon and cutoff^2.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data with
// no wait; the user must write them only while nothing is in flight, the
// block does not enforce it; an index past the last register is ignored.
module lj_pair_force (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic signed [lj_pkg::SEP_W-1:0] i_sep_x,
    input  logic signed [lj_pkg::SEP_W-1:0] i_sep_y,
    input  logic signed [lj_pkg::SEP_W-1:0] i_sep_z,
    input  logic [lj_pkg::ID_W-1:0]         i_id_i,
    input  logic [lj_pkg::ID_W-1:0]         i_id_j,
    input  logic                            i_cfg_we,
    input  logic [lj_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lj_pkg::CFG_W-1:0]        i_cfg_data,
    output logic                            empty,
    input  logic                            pop,
    output logic                            o_in_range,
    output logic signed [lj_pkg::OUT_W-1:0] o_force_x,
    output logic signed [lj_pkg::OUT_W-1:0] o_force_y,
    output logic signed [lj_pkg::OUT_W-1:0] o_force_z,
    output logic signed [lj_pkg::OUT_W-1:0] o_energy_term,
    output logic signed [lj_pkg::OUT_W-1:0] o_stress_xx,
    output logic signed [lj_pkg::OUT_W-1:0] o_stress_yy,
    output logic signed [lj_pkg::OUT_W-1:0] o_stress_zz,
    output logic signed [lj_pkg::OUT_W-1:0] o_stress_xy,
    output logic signed [lj_pkg::OUT_W-1:0] o_stress_xz,
    output logic signed [lj_pkg::OUT_W-1:0] o_stress_yz
);
    import lj_pkg::*;

    logic [S6_W-1:0]  r_sigma_sixth;
    logic [EPS_W-1:0] r_well_depth;
    logic [CUT_W-1:0] r_cutoff_sq;

    logic           front_vld;
    t_pair          front_pair;
    logic           fifo_full, fifo_empty, fifo_push, fifo_pop;
    t_pair          fifo_head;
    logic           back_en;
    logic           div_vld;
    t_side          div_side;
    logic [Q_W-1:0] div_u;
    logic [Q_W-1:0] s6q, eps_q, pe;
    logic           back_vld;
    t_result        back_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma_sixth <= SIGMA_SIXTH_RST;
            r_well_depth  <= WELL_DEPTH_RST;
            r_cutoff_sq   <= CUTOFF_SQ_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SIGMA_SIXTH: r_sigma_sixth <= i_cfg_data[S6_W-1:0];
                CFG_WELL_DEPTH:  r_well_depth  <= i_cfg_data[EPS_W-1:0];
                CFG_CUTOFF_SQ:   r_cutoff_sq   <= i_cfg_data[CUT_W-1:0];
                default: ;
            endcase
        end
    end

    assign s6q   = Q_W'(r_sigma_sixth) << EN_SHIFT;
    assign eps_q = Q_W'(r_well_depth) << EPS_SHIFT;

    // eps*s6 depends only on configuration, so it runs free
    lj_mul64 u_mul_pe (.i_clk, .i_en(1'b1), .i_a(eps_q), .i_b(s6q),
                       .i_wide(1'b0), .o_p(pe));

    lj_front u_front (
        .i_clk, .i_rst_n,
        .i_en(!fifo_full),
        .i_push(push),
        .i_sep_x, .i_sep_y, .i_sep_z,
        .i_id_i, .i_id_j,
        .i_cutoff_sq(r_cutoff_sq),
        .o_valid(front_vld),
        .o_pair(front_pair)
    );

    assign fifo_push = !fifo_full && front_vld;
    assign back_en   = !back_vld || pop;
    assign fifo_pop  = back_en && !fifo_empty;

    lj_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_push(fifo_push),
        .i_data(front_pair),
        .i_pop(fifo_pop),
        .o_data(fifo_head),
        .o_empty(fifo_empty),
        .o_full(fifo_full)
    );

    lj_recip u_recip (
        .i_clk, .i_rst_n,
        .i_en(back_en),
        .i_valid(!fifo_empty),
        .i_pair(fifo_head),
        .o_valid(div_vld),
        .o_side(div_side),
        .o_u(div_u)
    );

    lj_back u_back (
        .i_clk, .i_rst_n,
        .i_en(back_en),
        .i_valid(div_vld),
        .i_side(div_side),
        .i_u(div_u),
        .i_s6q(s6q),
        .i_pe(pe),
        .o_valid(back_vld),
        .o_res(back_res)
    );

    assign full          = fifo_full;
    assign empty         = !back_vld;
    assign o_in_range    = back_res.in_range;
    assign o_force_x     = back_res.frc[0];
    assign o_force_y     = back_res.frc[1];
    assign o_force_z     = back_res.frc[2];
    assign o_energy_term = back_res.eng;
    assign o_stress_xx   = back_res.vir[0];
    assign o_stress_yy   = back_res.vir[1];
    assign o_stress_zz   = back_res.vir[2];
    assign o_stress_xy   = back_res.vir[3];
    assign o_stress_xz   = back_res.vir[4];
    assign o_stress_yz   = back_res.vir[5];

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown right after reset");

    a_out_of_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_in_range) |-> (o_force_x == 0 && o_force_y == 0 &&
        o_force_z == 0 && o_energy_term == 0 && o_stress_xx == 0 && o_stress_xy == 0))
        else $error("pair out of range gives nonzero result");

    a_diag_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_stress_xx[OUT_W-1]) |-> (o_stress_yy[OUT_W-1] || o_stress_yy == 0))
        else $error("diagonal virial terms disagree in sign");

endmodule

// ----- verif/tb.sv -----
// self-checking testbench for the lennard-jones pair force kernel
`timescale 1ns / 100ps

module tb;
    import lj_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 120;

    typedef struct {
        logic        in_range;
        logic [31:0] frc[3];
        logic [31:0] eng;
        logic [31:0] vir[6];
    } t_pair_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   push;
    logic                   full;
    logic signed [SEP_W-1:0] i_sep_x, i_sep_y, i_sep_z;
    logic [ID_W-1:0]        i_id_i, i_id_j;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_W-1:0]       i_cfg_data;
    logic                   empty;
    logic                   pop;
    logic                   o_in_range;
    logic signed [OUT_W-1:0] o_force_x, o_force_y, o_force_z, o_energy_term;
    logic signed [OUT_W-1:0] o_stress_xx, o_stress_yy, o_stress_zz;
    logic signed [OUT_W-1:0] o_stress_xy, o_stress_xz, o_stress_yz;

    lj_pair_force u_dut (.*);

    // local copy of the registers
    logic [63:0] sig6_reg, eps_reg, cut_reg;

    t_pair_result pending_results[$];
    int err_count;
    int in_idle_pct;
    int out_idle_pct;
    int hold_cycles;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // (a*b) >> s, saturating to 64 bits
    function automatic logic [63:0] mul_trunc(input logic [63:0] a, input logic [63:0] b,
                                              input int s);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        if ((prod >> (64 + s)) != 0) return '1;
        return 64'(prod >> s);
    endfunction

    function automatic logic [63:0] mul_const(input logic [63:0] a, input int k);
        logic [127:0] prod;
        prod = {64'd0, a} * 128'(k);
        if (prod[127:64] != 0) return '1;
        return prod[63:0];
    endfunction

    function automatic logic [31:0] to_q16(input logic [63:0] mag, input logic neg);
        if (neg) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
        return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function automatic t_pair_result lj_predict(input logic [SEP_W-1:0] sx,
                                                input logic [SEP_W-1:0] sy,
                                                input logic [SEP_W-1:0] sz,
                                                input logic [ID_W-1:0] idi,
                                                input logic [ID_W-1:0] idj);
        t_pair_result res;
        logic [SEP_W-1:0] raw[3];
        logic [63:0] mag[3];
        logic neg[3];
        logic [63:0] r2, u, u6, s6q, a, t, a12, g, p, fr, em;
        logic [127:0] quo;
        logic eneg, frneg;
        int ax[3];
        int bx[3];
        ax = '{0, 0, 1};
        bx = '{1, 2, 2};
        raw = '{sx, sy, sz};
        r2 = 0;
        res.in_range = 1'b0;
        res.eng = 0;
        for (int c = 0; c < 3; c++) begin
            res.frc[c] = 0;
            neg[c] = raw[c][SEP_W-1];
            mag[c] = neg[c] ? 64'(25'h100_0000 - raw[c]) : 64'(raw[c]);
            r2 += mag[c] * mag[c];
        end
        for (int c = 0; c < 6; c++) res.vir[c] = 0;
        if (!(idj > idi) || r2 > (cut_reg << FRAC_BITS)) return res;
        res.in_range = 1'b1;
        if (r2 == 0) begin
            u = '1;
        end else begin
            quo = (128'd1 << (32 + 2 * FRAC_BITS)) / r2;
            u = (quo[127:64] != 0) ? '1 : quo[63:0];
        end
        u6 = mul_trunc(mul_trunc(u, u, 32), u, 32);
        s6q = sig6_reg << (32 - FRAC_BITS);
        a = mul_trunc(s6q, u6, 32);
        eneg = (a < 64'h1_0000_0000);
        t = eneg ? (64'h1_0000_0000 - a) : (a - 64'h1_0000_0000);
        em = mul_trunc(u6, t, 32) >> (32 - FRAC_BITS);
        res.eng = to_q16(em, eneg);
        a12 = mul_const(a, 12);
        frneg = (a12 >= 64'h6_0000_0000);
        g = frneg ? (a12 - 64'h6_0000_0000) : (64'h6_0000_0000 - a12);
        p = mul_trunc(eps_reg << 8, s6q, 32);
        p = mul_trunc(p, u6, 32);
        p = mul_trunc(p, u, 32);
        p = mul_const(p, 4);
        fr = mul_trunc(p, g, 32);
        for (int c = 0; c < 3; c++) begin
            res.frc[c] = to_q16(mul_trunc(fr, mag[c], 32), frneg != neg[c]);
            res.vir[c] = to_q16(mul_trunc(fr, mag[c] * mag[c], 32 + FRAC_BITS), !frneg);
            res.vir[3 + c] = to_q16(mul_trunc(fr, mag[ax[c]] * mag[bx[c]], 32 + FRAC_BITS),
                                    (!frneg) != (neg[ax[c]] != neg[bx[c]]));
        end
        return res;
    endfunction

    // one pair onto the input queue; returns at the falling edge after the transfer
    task automatic send_pair(input logic [SEP_W-1:0] sx, input logic [SEP_W-1:0] sy,
                             input logic [SEP_W-1:0] sz, input logic [ID_W-1:0] idi,
                             input logic [ID_W-1:0] idj);
        while ($urandom_range(99) < in_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push    <= 1'b1;
        i_sep_x <= sx;
        i_sep_y <= sy;
        i_sep_z <= sz;
        i_id_i  <= idi;
        i_id_j  <= idj;
        do @(posedge i_clk); while (full);
        pending_results.push_back(lj_predict(sx, sy, sz, idi, idj));
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        push <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SIGMA_SIXTH: sig6_reg = 64'(val[S6_W-1:0]);
            CFG_WELL_DEPTH:  eps_reg  = 64'(val);
            CFG_CUTOFF_SQ:   cut_reg  = 64'(val[CUT_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [CFG_W-1:0] s6, input logic [CFG_W-1:0] eps,
                            input logic [CFG_W-1:0] cut);
        write_reg(CFG_SIGMA_SIXTH, s6);
        write_reg(CFG_WELL_DEPTH, eps);
        write_reg(CFG_CUTOFF_SQ, cut);
    endtask

    // largest per-axis magnitude for which dims axes of that size stay inside the cutoff
    function automatic int axis_limit(input int dims);
        longint lim;
        longint bound;
        bound = longint'(cut_reg) << FRAC_BITS;
        lim = longint'($sqrt(real'(bound) / dims));
        while (lim > 0 && dims * lim * lim > bound) lim--;
        while (dims * (lim + 1) * (lim + 1) <= bound && lim < 64'h7F_FFFF) lim++;
        return int'(lim);
    endfunction

    task automatic send_random(input int count);
        int lim;
        int mode;
        logic [SEP_W-1:0] d[3];
        logic [ID_W-1:0] idi, idj;
        lim = axis_limit(3);
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(9);
            idi = ID_W'($urandom_range(20'hFFFFE));
            idj = ID_W'($urandom_range(20'hFFFFF, idi + 1));
            for (int c = 0; c < 3; c++) begin
                if (mode < 6)
                    d[c] = SEP_W'($urandom_range(2 * lim) - lim);
                else if (mode < 7)
                    d[c] = SEP_W'($urandom_range(64) - 32);
                else
                    d[c] = SEP_W'($urandom);
            end
            // noise: ids in any order
            if (mode == 9) begin
                idi = ID_W'($urandom);
                idj = ID_W'($urandom);
            end
            send_pair(d[0], d[1], d[2], idi, idj);
        end
        push <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic test_directed;
        int lim;
        lim = axis_limit(1);
        send_pair(0, 0, 0, 20'd0, 20'd1);
        send_pair(0, 0, 0, 20'd5, 20'd5);
        send_pair(24'h010000, 0, 0, 20'd9, 20'd3);
        send_pair(24'h010000, 24'hFF0000, 24'h008000, 20'd0, 20'hFFFFF);
        send_pair(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 20'd0, 20'hFFFFF);
        send_pair(24'h800000, 24'h800000, 24'h800000, 20'd1, 20'd2);
        send_pair(24'h000001, 0, 0, 20'd1, 20'd2);
        send_pair(24'hFFFFFF, 24'h000001, 24'hFFFFFF, 20'd1, 20'd2);
        send_pair(SEP_W'(lim), 0, 0, 20'd3, 20'd4);
        send_pair(SEP_W'(lim + 1), 0, 0, 20'd3, 20'd4);
        send_pair(SEP_W'(-lim), 0, 0, 20'd3, 20'd4);
        send_pair(0, SEP_W'(-lim - 1), 0, 20'd3, 20'd4);
        send_pair(24'h018000, 24'hFE8000, 24'h010000, 20'hFFFFE, 20'hFFFFF);
        send_pair(24'h020000, 24'h010000, 24'hFF0000, 20'h12345, 20'h54321);
        send_pair(24'h00C000, 24'h00C000, 24'h00C000, 20'h00010, 20'h00100);
        send_pair(24'h030000, 24'hFD0000, 24'h030000, 20'd7, 20'd8);
        push <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic test_sparse_sender;
        in_idle_pct = 78;
        out_idle_pct = 7;
        set_regs(32'd500000, 32'd16777216, 32'd2000000);
        send_random(136);
    endtask

    task automatic test_slow_receiver;
        in_idle_pct = 7;
        out_idle_pct = 78;
        send_random(136);
    endtask

    task automatic test_register_extremes;
        in_idle_pct = 0;
        out_idle_pct = 0;
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        set_regs(32'hFF_FFFF, 32'hFFFF_FFFF, 32'hFF_FFFF);
        send_random(80);
        set_regs(32'd0, 32'd0, 32'd0);
        send_pair(0, 0, 0, 20'd1, 20'd2);
        send_pair(24'h000001, 0, 0, 20'd1, 20'd2);
        send_random(40);
        set_regs($urandom_range(24'hFF_FFFF), $urandom, $urandom_range(24'h20_0000));
        send_random(80);
    endtask

    task automatic test_backpressure;
        set_regs(32'd840676, 32'd142606, 32'd1380735);
        @(posedge i_clk);
        hold_cycles = 400;
        @(negedge i_clk);
        send_random(160);
    endtask

    // receiver: random pop with an optional long hold-off
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= out_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_pair_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                $display("unexpected result at %0t", $realtime);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_in_range !== want.in_range)
                    report_mismatch("in_range", 32'(o_in_range), 32'(want.in_range));
                if (o_force_x !== want.frc[0]) report_mismatch("force_x", o_force_x, want.frc[0]);
                if (o_force_y !== want.frc[1]) report_mismatch("force_y", o_force_y, want.frc[1]);
                if (o_force_z !== want.frc[2]) report_mismatch("force_z", o_force_z, want.frc[2]);
                if (o_energy_term !== want.eng)
                    report_mismatch("energy_term", o_energy_term, want.eng);
                if (o_stress_xx !== want.vir[0])
                    report_mismatch("stress_xx", o_stress_xx, want.vir[0]);
                if (o_stress_yy !== want.vir[1])
                    report_mismatch("stress_yy", o_stress_yy, want.vir[1]);
                if (o_stress_zz !== want.vir[2])
                    report_mismatch("stress_zz", o_stress_zz, want.vir[2]);
                if (o_stress_xy !== want.vir[3])
                    report_mismatch("stress_xy", o_stress_xy, want.vir[3]);
                if (o_stress_xz !== want.vir[4])
                    report_mismatch("stress_xz", o_stress_xz, want.vir[4]);
                if (o_stress_yz !== want.vir[5])
                    report_mismatch("stress_yz", o_stress_yz, want.vir[5]);
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        err_count = 0;
        quiet_cycles = 0;
        hold_cycles = 0;
        in_idle_pct = 7;
        out_idle_pct = 78;
        sig6_reg = 64'(SIGMA_SIXTH_RST);
        eps_reg  = 64'(WELL_DEPTH_RST);
        cut_reg  = 64'(CUTOFF_SQ_RST);
        i_rst_n = 1'b0;
        push = 1'b0;
        i_sep_x = '0;
        i_sep_y = '0;
        i_sep_z = '0;
        i_id_i = '0;
        i_id_j = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_SIGMA_SIXTH;
        i_cfg_data = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed;
        send_random(100);
        test_sparse_sender;
        test_slow_receiver;
        test_register_extremes;
        test_backpressure;

        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
